>>> sv/can_frame_rx_fifo_with_stats_unit_assert.svh
// Assertion helpers used by the queue RTL.
`ifndef CAN_FRAME_RX_FIFO_WITH_STATS_UNIT_ASSERT_SVH
`define CAN_FRAME_RX_FIFO_WITH_STATS_UNIT_ASSERT_SVH

// same-cycle implication
`define CANRXQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CANRXQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/canrxq_pkg.sv
`default_nettype none
package canrxq_pkg;

   localparam int QUEUE_DEPTH_DEF = 128;
   localparam int MAX_DLC         = 8;

   typedef enum logic [1:0] {
      CMD_RECEIVE  = 2'd0,
      CMD_POP      = 2'd1,
      CMD_TRANSMIT = 2'd2,
      CMD_CLEAR    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_INVALID = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // one queued frame as held in the frame memory
   typedef struct packed {
      logic [31:0] id;
      logic [3:0]  dlc;
      logic [63:0] payload;
   } frame_entry_type;

endpackage
`default_nettype wire

>>> sv/canrxq_req_if.sv
`default_nettype none
interface canrxq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [31:0] frame_id;
   logic [7:0]  frame_dlc;
   logic [63:0] frame_payload;
   logic        length_ok;

   modport source (
      output valid, cmd, frame_id, frame_dlc, frame_payload, length_ok,
      input  ready
   );
   modport sink (
      input  valid, cmd, frame_id, frame_dlc, frame_payload, length_ok,
      output ready
   );
endinterface
`default_nettype wire

>>> sv/canrxq_rsp_if.sv
`default_nettype none
interface canrxq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] out_id;
   logic [3:0]  out_dlc;
   logic [63:0] out_payload;
   logic [7:0]  fill_level;
   logic [63:0] received_total;
   logic [63:0] dropped_total;
   logic [63:0] sent_total;

   modport source (
      output valid, status, out_id, out_dlc, out_payload, fill_level,
             received_total, dropped_total, sent_total,
      input  ready
   );
   modport sink (
      input  valid, status, out_id, out_dlc, out_payload, fill_level,
             received_total, dropped_total, sent_total,
      output ready
   );
endinterface
`default_nettype wire

>>> sv/canrxq_store.sv
`default_nettype none
module canrxq_store
   import canrxq_pkg::*;
#(
   parameter int DEPTH  = QUEUE_DEPTH_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire frame_entry_type wr_data,
   input  wire logic            rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output frame_entry_type      rd_data
);

   frame_entry_type frame_mem [DEPTH];
   frame_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[wr_addr] <= wr_data;
      end
   end

   // read word holds until the next pop so a stalled result keeps its data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= frame_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> sv/can_frame_rx_fifo_with_stats_unit.sv
`default_nettype none
// CAN frame receive queue with statistics. While results are taken it takes
// one command word per clock (receive, pop, transmit, clear) and returns
// exactly one result word for each, in the cycle after acceptance. The result
// sits in an output register and a new command is accepted in the same cycle
// the previous result is taken, so with the sink always ready the sustained
// rate is one command per cycle. Frames live in a single memory of QUEUE_DEPTH
// entries with one write and one registered read port; a pop issues its read
// when accepted and the data appears with the result. Pointers, fill count and
// the three 64-bit counters are flip-flops updated in the accepting cycle. No
// clearing pass is needed after reset: an entry is only ever read after it has
// been written. Clear empties the queue but leaves the counters alone.
`include "can_frame_rx_fifo_with_stats_unit_assert.svh"
module can_frame_rx_fifo_with_stats_unit
   import canrxq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input wire logic      clock,
   input wire logic      reset,
   canrxq_req_if.sink    req_chan,
   canrxq_rsp_if.source  rsp_chan
);

   localparam int ADDR_W = $clog2(QUEUE_DEPTH);
   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 1);

   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [63:0]       rx_cnt_ff, rx_cnt_in;
   logic [63:0]       drop_cnt_ff, drop_cnt_in;
   logic [63:0]       tx_cnt_ff, tx_cnt_in;
   status_type        status_ff, status_in;
   logic              pop_ok_ff, pop_ok_in;
   logic              rsp_valid_ff;

   logic              accept;
   logic              frame_valid;
   logic              q_full;
   logic              q_empty;
   logic              push_req;
   logic              pop_req;
   frame_entry_type   wr_word;
   frame_entry_type   rd_word;

   function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign frame_valid = req_chan.length_ok && (req_chan.frame_dlc <= 8'(MAX_DLC));
   assign q_full      = occ_ff >= OCC_W'(QUEUE_DEPTH);
   assign q_empty     = occ_ff == '0;

   always_comb begin
      wr_ptr_in   = wr_ptr_ff;
      rd_ptr_in   = rd_ptr_ff;
      occ_in      = occ_ff;
      rx_cnt_in   = rx_cnt_ff;
      drop_cnt_in = drop_cnt_ff;
      tx_cnt_in   = tx_cnt_ff;
      status_in   = ST_OK;
      pop_ok_in   = 1'b0;
      push_req    = 1'b0;
      pop_req     = 1'b0;
      case (cmd_type'(req_chan.cmd))
         CMD_RECEIVE: begin
            if (!frame_valid) begin
               status_in   = ST_INVALID;
               drop_cnt_in = drop_cnt_ff + 64'd1;
            end else if (q_full) begin
               status_in   = ST_FULL;
               drop_cnt_in = drop_cnt_ff + 64'd1;
            end else begin
               push_req  = 1'b1;
               wr_ptr_in = next_slot(wr_ptr_ff);
               occ_in    = occ_ff + 1'b1;
               rx_cnt_in = rx_cnt_ff + 64'd1;
            end
         end
         CMD_POP: begin
            if (q_empty) begin
               status_in = ST_EMPTY;
            end else begin
               pop_req   = 1'b1;
               pop_ok_in = 1'b1;
               rd_ptr_in = next_slot(rd_ptr_ff);
               occ_in    = occ_ff - 1'b1;
            end
         end
         CMD_TRANSMIT: begin
            if (!frame_valid) begin
               status_in = ST_INVALID;
            end else begin
               tx_cnt_in = tx_cnt_ff + 64'd1;
            end
         end
         CMD_CLEAR: begin
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            occ_in    = '0;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   // state doubles as the result register: counters shown are post-step values
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         occ_ff      <= '0;
         rx_cnt_ff   <= '0;
         drop_cnt_ff <= '0;
         tx_cnt_ff   <= '0;
         pop_ok_ff   <= 1'b0;
         status_ff   <= ST_OK;
      end else if (accept) begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         occ_ff      <= occ_in;
         rx_cnt_ff   <= rx_cnt_in;
         drop_cnt_ff <= drop_cnt_in;
         tx_cnt_ff   <= tx_cnt_in;
         pop_ok_ff   <= pop_ok_in;
         status_ff   <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign wr_word.id      = req_chan.frame_id;
   assign wr_word.dlc     = req_chan.frame_dlc[3:0];
   assign wr_word.payload = req_chan.frame_payload;

   canrxq_store #(
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && push_req),
      .wr_addr (wr_ptr_ff),
      .wr_data (wr_word),
      .rd_en   (accept && pop_req),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_word)
   );

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = status_ff;
   assign rsp_chan.out_id         = pop_ok_ff ? rd_word.id : '0;
   assign rsp_chan.out_dlc        = pop_ok_ff ? rd_word.dlc : '0;
   assign rsp_chan.out_payload    = pop_ok_ff ? rd_word.payload : '0;
   assign rsp_chan.fill_level     = 8'(occ_ff);
   assign rsp_chan.received_total = rx_cnt_ff;
   assign rsp_chan.dropped_total  = drop_cnt_ff;
   assign rsp_chan.sent_total     = tx_cnt_ff;

   `CANRXQ_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1,
      occ_ff <= OCC_W'(QUEUE_DEPTH), "fill count beyond queue depth")
   `CANRXQ_ASSERT_NOW(a_empty_ptrs, clock, reset, q_empty,
      wr_ptr_ff == rd_ptr_ff, "empty queue with pointers apart")
   `CANRXQ_ASSERT_NEXT(a_push_count, clock, reset, !reset && accept && push_req,
      (rx_cnt_ff == $past(rx_cnt_ff) + 64'd1) && (occ_ff == $past(occ_ff) + 1'b1),
      "push did not advance receive count and fill")
   `CANRXQ_ASSERT_NEXT(a_pop_empty, clock, reset,
      !reset && accept && (req_chan.cmd == CMD_POP) && q_empty,
      (status_ff == ST_EMPTY) && !pop_ok_ff, "pop on empty queue not reported")

endmodule
`default_nettype wire
